[design/mcdt_pkg.sv]
package mcdt_pkg;

    localparam int TIME_W    = 32;
    localparam int CMD_W     = 3;
    localparam int CH_W      = 3;
    localparam int FIRED_W   = 8;
    localparam int MASK_IDX_W = 3;
    localparam int DIV_STEPS = TIME_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // A deadline of all ones marks a stopped channel.
    localparam logic [TIME_W-1:0] DL_STOPPED = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_SERVICE    = 3'd0,
        CMD_SET_PERIOD = 3'd1,
        CMD_START_ONCE = 3'd2,
        CMD_START_REP  = 3'd3,
        CMD_DISABLE    = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_WALK,
        ST_DIV,
        ST_ADJ,
        ST_UPD,
        ST_REPORT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_rem_stat;

endpackage

[design/multi_channel_deadline_timer_unit.sv]
// Channel   Direction  Handshake            Payload
// request   in         i_valid / o_stall    i_command, i_channel, i_period_ms, i_now_ms
// result    out        o_valid / i_stall    o_fired_mask, o_nearest_deadline,
//                                           o_channel_running
//
// Each request runs through the sequencer in order: the command is applied, the bank is
// walked one channel at a time, the result is reported and the sequencer returns to idle,
// where the next request is taken. A repeating channel that fires during a service adds
// a catch-up in the shared remainder unit (ST_DIV, ST_ADJ, then ST_UPD), or goes straight
// to ST_UPD when its period is zero. Reset is synchronous and active low; every channel
// comes out stopped. o_stall is high from acceptance until the result is loaded into the
// output register; a stalled result holds and the next request may be taken meanwhile.
module multi_channel_deadline_timer_unit import mcdt_pkg::*; #(
    parameter int CHANNELS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [CH_W-1:0]    i_channel,
    input  logic [TIME_W-1:0]  i_period_ms,
    input  logic [TIME_W-1:0]  i_now_ms,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [FIRED_W-1:0] o_fired_mask,
    output logic [TIME_W-1:0]  o_nearest_deadline,
    output logic               o_channel_running
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Channel bank
    logic [TIME_W-1:0]  r_dl  [CHANNELS];
    logic [TIME_W-1:0]  r_per [CHANNELS];
    logic               r_rep [CHANNELS];

    // Sequencer and request registers
    t_state             r_state, n_state;
    logic [CMD_W-1:0]   r_cmd;
    logic [CH_W-1:0]    r_ch;
    logic [TIME_W-1:0]  r_perin;
    logic [TIME_W-1:0]  r_now;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [FIRED_W-1:0] r_mask, n_mask;
    logic [TIME_W-1:0]  r_min, n_min;
    logic [TIME_W-1:0]  r_adj, n_adj;

    // Output register
    logic               r_ov;
    logic [FIRED_W-1:0] r_omask;
    logic [TIME_W-1:0]  r_omin;
    logic               r_orun;

    logic               accept;
    logic               out_load;
    logic               ch_ok;
    logic [IDX_W-1:0]   ch_idx;
    logic [IDX_W-1:0]   rd_idx;
    logic [TIME_W-1:0]  d_rd;
    logic [TIME_W-1:0]  p_rd;
    logic               expired;
    logic               dl_we;
    logic [TIME_W-1:0]  dl_wdata;
    logic               per_we;
    logic               rep_we;
    logic               rep_wdata;
    logic               step_done;
    logic [TIME_W-1:0]  cand;
    logic               rem_start;
    logic [TIME_W-1:0]  rem_val;
    t_rem_stat          rem_stat;

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != ST_IDLE);
    assign ch_ok   = (32'(r_ch) < CHANNELS);
    assign ch_idx  = IDX_W'(r_ch);

    // The bank has a single read address, shared by every phase.
    assign rd_idx  = (r_state == ST_CMD || r_state == ST_REPORT) ? ch_idx : r_idx;
    assign d_rd    = r_dl[rd_idx];
    assign p_rd    = r_per[rd_idx];
    assign expired = (d_rd != DL_STOPPED) && (d_rd <= r_now);

    assign out_load = (r_state == ST_REPORT) && (!r_ov || !i_stall);

    mcdt_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rem_start),
        .i_num   (r_now - d_rd),
        .i_den   (p_rd),
        .o_rem   (rem_val),
        .o_stat  (rem_stat)
    );

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_mask    = r_mask;
        n_min     = r_min;
        n_adj     = r_adj;
        dl_we     = 1'b0;
        dl_wdata  = DL_STOPPED;
        per_we    = 1'b0;
        rep_we    = 1'b0;
        rep_wdata = 1'b0;
        step_done = 1'b0;
        cand      = d_rd;
        rem_start = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_CMD;
                end
            end
            ST_CMD: begin
                if (ch_ok) begin
                    case (t_cmd'(r_cmd))
                        CMD_SET_PERIOD: begin
                            per_we = 1'b1;
                        end
                        CMD_START_ONCE: begin
                            rep_we    = 1'b1;
                            rep_wdata = 1'b0;
                            dl_we     = 1'b1;
                            dl_wdata  = r_now + p_rd;
                        end
                        CMD_START_REP: begin
                            rep_we    = 1'b1;
                            rep_wdata = 1'b1;
                            dl_we     = 1'b1;
                            dl_wdata  = r_now + p_rd;
                        end
                        CMD_DISABLE: begin
                            rep_we    = 1'b1;
                            rep_wdata = 1'b0;
                            dl_we     = 1'b1;
                            dl_wdata  = DL_STOPPED;
                        end
                        default: begin
                        end
                    endcase
                end
                n_idx   = '0;
                n_mask  = '0;
                n_min   = DL_STOPPED;
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (r_cmd == CMD_SERVICE && expired) begin
                    if (32'(r_idx) < FIRED_W) begin
                        n_mask[MASK_IDX_W'(r_idx)] = 1'b1;
                    end
                    if (r_rep[rd_idx]) begin
                        if (p_rd == '0) begin
                            // A zero period lands the deadline on the current time.
                            n_adj   = '0;
                            n_state = ST_UPD;
                        end else begin
                            rem_start = 1'b1;
                            n_state   = ST_DIV;
                        end
                    end else begin
                        dl_we     = 1'b1;
                        dl_wdata  = DL_STOPPED;
                        cand      = DL_STOPPED;
                        step_done = 1'b1;
                    end
                end else begin
                    step_done = 1'b1;
                end
            end
            ST_DIV: begin
                if (rem_stat.done) begin
                    n_state = ST_ADJ;
                end
            end
            ST_ADJ: begin
                // Whole periods past the gap: now + (period - gap mod period), now + period when
                // the deadline is exactly now, or now when the gap is a whole number of periods.
                if (rem_val != '0) begin
                    n_adj = p_rd - rem_val;
                end else if (d_rd == r_now) begin
                    n_adj = p_rd;
                end else begin
                    n_adj = '0;
                end
                n_state = ST_UPD;
            end
            ST_UPD: begin
                dl_we     = 1'b1;
                dl_wdata  = r_now + r_adj;
                cand      = dl_wdata;
                step_done = 1'b1;
            end
            ST_REPORT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (step_done) begin
            if (cand < r_min) begin
                n_min = cand;
            end
            if (r_idx == IDX_W'(CHANNELS - 1)) begin
                n_state = ST_REPORT;
            end else begin
                n_idx   = r_idx + 1'b1;
                n_state = ST_WALK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_dl[i]  <= DL_STOPPED;
                r_per[i] <= '0;
                r_rep[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            if (dl_we) begin
                r_dl[rd_idx] <= dl_wdata;
            end
            if (per_we) begin
                r_per[rd_idx] <= r_perin;
            end
            if (rep_we) begin
                r_rep[rd_idx] <= rep_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_command;
            r_ch    <= i_channel;
            r_perin <= i_period_ms;
            r_now   <= i_now_ms;
        end
        r_idx  <= n_idx;
        r_mask <= n_mask;
        r_min  <= n_min;
        r_adj  <= n_adj;
        if (out_load) begin
            r_omask <= r_mask;
            r_omin  <= r_min;
            r_orun  <= ch_ok && (d_rd != DL_STOPPED);
        end
    end

    assign o_valid            = r_ov;
    assign o_fired_mask       = r_omask;
    assign o_nearest_deadline = r_omin;
    assign o_channel_running  = r_orun;

    a_rem_start_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_start |-> (r_state == ST_WALK && p_rd != '0 && !rem_stat.busy))
        else $error("remainder unit started outside a repeating fire");

    a_rem_done_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_stat.done |-> (r_state == ST_DIV))
        else $error("remainder result arrived while the sequencer was not waiting");

    a_min_falls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && $past(r_state) == ST_WALK) |-> (r_min <= $past(r_min)))
        else $error("nearest deadline grew during the walk");

    a_mask_service: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REPORT && r_cmd != CMD_SERVICE) |-> (r_mask == '0))
        else $error("channels fired outside a service request");

    a_report_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_state == ST_IDLE && r_ov))
        else $error("result load did not finish the request");

endmodule

[design/mcdt_rem.sv]
module mcdt_rem import mcdt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TIME_W-1:0] i_num,
    input  logic [TIME_W-1:0] i_den,
    output logic [TIME_W-1:0] o_rem,
    output t_rem_stat         o_stat
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [TIME_W-1:0]    r_num;
    logic [TIME_W-1:0]    r_part;
    logic [TIME_W-1:0]    r_den;

    logic [TIME_W:0]      trial;
    logic [TIME_W:0]      diff;
    logic [TIME_W-1:0]    n_part;

    // One restoring step a cycle: bring down the next numerator bit and
    // subtract the divisor when it fits.
    always_comb begin
        trial  = {r_part, r_num[TIME_W-1]};
        diff   = trial - {1'b0, r_den};
        n_part = diff[TIME_W] ? trial[TIME_W-1:0] : diff[TIME_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_part <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_num  <= {r_num[TIME_W-2:0], 1'b0};
            r_part <= n_part;
        end
    end

    assign o_rem       = r_part;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

[dv/multi_channel_deadline_timer_unit_tb.sv]
module multi_channel_deadline_timer_unit_tb import mcdt_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CH = 8;
    localparam int RANDOM_REQUESTS = 900;
    localparam int DRAIN_CYCLES = 400;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER = 200;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [FIRED_W-1:0] fired_mask;
        logic [TIME_W-1:0]  nearest_deadline;
        logic               channel_running;
    } t_timer_report;

    typedef enum int {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } t_rx_mode;

    class deadline_scoreboard;
        logic [TIME_W-1:0] deadlines [NUM_CH];
        logic [TIME_W-1:0] periods [NUM_CH];
        bit                repeating [NUM_CH];
        t_timer_report     pending_reports [$];
        int unsigned       failures;
        int unsigned       checked;

        function new();
            for (int i = 0; i < NUM_CH; i++) begin
                deadlines[i] = DL_STOPPED;
                periods[i]   = '0;
                repeating[i] = 1'b0;
            end
            failures = 0;
            checked  = 0;
        endfunction

        // Smallest whole number of periods (at least one) that reaches now,
        // worked out in 64 bits and then folded back to the timer width.
        function logic [TIME_W-1:0] caught_up(input logic [TIME_W-1:0] dl,
                                              input logic [TIME_W-1:0] per,
                                              input logic [TIME_W-1:0] now);
            logic [63:0] gap;
            logic [63:0] steps;
            logic [63:0] sum;
            if (per == '0) begin
                return now;
            end
            gap   = {32'd0, now} - {32'd0, dl};
            steps = (gap + {32'd0, per} - 64'd1) / {32'd0, per};
            if (steps == 64'd0) begin
                steps = 64'd1;
            end
            sum = {32'd0, dl} + steps * {32'd0, per};
            return sum[TIME_W-1:0];
        endfunction

        function void note_request(input logic [CMD_W-1:0]  cmd,
                                   input logic [CH_W-1:0]   ch,
                                   input logic [TIME_W-1:0] per,
                                   input logic [TIME_W-1:0] now);
            t_timer_report rep;
            bit            addressed_ok;
            rep = '0;
            addressed_ok = (int'(ch) < NUM_CH);
            if (cmd == CMD_SERVICE) begin
                for (int i = 0; i < NUM_CH; i++) begin
                    if (deadlines[i] != DL_STOPPED && deadlines[i] <= now) begin
                        if (i < FIRED_W) begin
                            rep.fired_mask[i] = 1'b1;
                        end
                        deadlines[i] = repeating[i] ?
                                       caught_up(deadlines[i], periods[i], now) : DL_STOPPED;
                    end
                end
            end else if (addressed_ok) begin
                case (cmd)
                    CMD_SET_PERIOD: begin
                        periods[ch] = per;
                    end
                    CMD_START_ONCE: begin
                        repeating[ch] = 1'b0;
                        deadlines[ch] = now + periods[ch];
                    end
                    CMD_START_REP: begin
                        repeating[ch] = 1'b1;
                        deadlines[ch] = now + periods[ch];
                    end
                    CMD_DISABLE: begin
                        deadlines[ch] = DL_STOPPED;
                        repeating[ch] = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            rep.nearest_deadline = DL_STOPPED;
            for (int i = 0; i < NUM_CH; i++) begin
                if (deadlines[i] < rep.nearest_deadline) begin
                    rep.nearest_deadline = deadlines[i];
                end
            end
            rep.channel_running = addressed_ok && (deadlines[ch] != DL_STOPPED);
            pending_reports.push_back(rep);
        endfunction

        function void check_result(input logic [FIRED_W-1:0] fired,
                                   input logic [TIME_W-1:0]  nearest,
                                   input logic               running);
            t_timer_report want;
            checked++;
            if (pending_reports.size() == 0) begin
                failures++;
                $error("result with no request outstanding: fired_mask %0h", fired);
                return;
            end
            want = pending_reports.pop_front();
            if (fired !== want.fired_mask) begin
                failures++;
                $error("fired_mask: expected %0h, actual %0h", want.fired_mask, fired);
            end
            if (nearest !== want.nearest_deadline) begin
                failures++;
                $error("nearest_deadline: expected %0h, actual %0h",
                       want.nearest_deadline, nearest);
            end
            if (running !== want.channel_running) begin
                failures++;
                $error("channel_running: expected %0b, actual %0b",
                       want.channel_running, running);
            end
        endfunction

        function int outstanding();
            return pending_reports.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [CMD_W-1:0]   i_command = CMD_SERVICE;
    logic [CH_W-1:0]    i_channel = '0;
    logic [TIME_W-1:0]  i_period_ms = '0;
    logic [TIME_W-1:0]  i_now_ms = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [FIRED_W-1:0] o_fired_mask;
    logic [TIME_W-1:0]  o_nearest_deadline;
    logic               o_channel_running;

    deadline_scoreboard sb = new();

    logic [TIME_W-1:0] tb_now = '0;
    int unsigned       burst_left = 0;

    multi_channel_deadline_timer_unit #(
        .CHANNELS(NUM_CH)
    ) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_command          (i_command),
        .i_channel          (i_channel),
        .i_period_ms        (i_period_ms),
        .i_now_ms           (i_now_ms),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_fired_mask       (o_fired_mask),
        .o_nearest_deadline (o_nearest_deadline),
        .o_channel_running  (o_channel_running)
    );

    always #4 i_clk = ~i_clk;

    // Bursts of back-to-back requests separated by gaps of random length; some
    // gaps are zero so that long stretches go through without idling.
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 40);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_request(input logic [CMD_W-1:0]  cmd,
                                input logic [CH_W-1:0]   ch,
                                input logic [TIME_W-1:0] per,
                                input logic [TIME_W-1:0] now);
        pace_sender();
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_channel   <= ch;
        i_period_ms <= per;
        i_now_ms    <= now;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(cmd, ch, per, now);
    endtask

    task automatic wait_for_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
    endtask

    // Time mostly creeps forward so that running channels actually expire;
    // now and then it jumps, or lands just short of the wrap.
    task automatic random_request();
        int unsigned       roll;
        logic [CMD_W-1:0]  cmd;
        logic [CH_W-1:0]   ch;
        logic [TIME_W-1:0] per;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            tb_now = tb_now + $urandom_range(0, 8);
        end else if (roll < 85) begin
            tb_now = tb_now + $urandom_range(0, 200);
        end else if (roll < 90) begin
            tb_now = $urandom;
        end else if (roll < 95) begin
            tb_now = DL_STOPPED - $urandom_range(0, 300);
        end
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
            per = '0;
        end else if (roll < 60) begin
            per = $urandom_range(1, 40);
        end else if (roll < 80) begin
            per = $urandom_range(41, 2000);
        end else if (roll < 90) begin
            per = $urandom;
        end else begin
            per = DL_STOPPED - $urandom_range(0, 50);
        end
        ch = CH_W'($urandom_range(0, NUM_CH - 1));
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            cmd = CMD_SERVICE;
        end else if (roll < 55) begin
            cmd = CMD_SET_PERIOD;
        end else if (roll < 70) begin
            cmd = CMD_START_ONCE;
        end else if (roll < 87) begin
            cmd = CMD_START_REP;
        end else if (roll < 97) begin
            cmd = CMD_DISABLE;
        end else begin
            cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        end
        send_request(cmd, ch, per, tb_now);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(CMD_SERVICE,    3'd0, '0,            32'd0);
        send_request(CMD_SET_PERIOD, 3'd0, DL_STOPPED,    DL_STOPPED);
        // Deadline lands on the stopped mark, so the channel stays stopped.
        send_request(CMD_START_ONCE, 3'd0, '0,            32'd0);
        send_request(CMD_SET_PERIOD, 3'd1, '0,            32'd0);
        send_request(CMD_START_REP,  3'd1, '0,            32'd100);
        send_request(CMD_SERVICE,    3'd1, '0,            32'd150);
        send_request(CMD_SET_PERIOD, 3'd2, 32'd10,        32'd0);
        send_request(CMD_START_REP,  3'd2, '0,            32'd0);
        send_request(CMD_SERVICE,    3'd2, '0,            32'd1000);
        // Deadline equal to now still fires, and catch-up moves a full period on.
        send_request(CMD_SERVICE,    3'd2, '0,            32'd1000);
        send_request(CMD_SET_PERIOD, 3'd3, 32'd7,         32'd0);
        send_request(CMD_START_ONCE, 3'd3, '0,            32'd5);
        send_request(CMD_SERVICE,    3'd3, '0,            32'd12);
        send_request(CMD_SET_PERIOD, 3'd5, 32'd16,        32'd0);
        send_request(CMD_START_REP,  3'd5, '0,            32'hFFFF_FFF0);
        send_request(CMD_SET_PERIOD, 3'd6, 32'd2,         32'd0);
        send_request(CMD_START_REP,  3'd6, '0,            32'h0000_00FF);
        // Catch-up wraps past the top for one channel and hits the stopped
        // mark for another.
        send_request(CMD_SERVICE,    3'd6, '0,            32'hFFFF_FFFE);
        send_request(CMD_SERVICE,    3'd6, '0,            DL_STOPPED);
        send_request(CMD_DISABLE,    3'd2, '0,            32'd0);
        send_request(CMD_UNUSED_LO,  3'd7, DL_STOPPED,    32'd0);
        send_request(CMD_UNUSED_HI,  3'd1, 32'd5,         32'd0);
        send_request(CMD_START_ONCE, 3'd7, '0,            32'd0);
        send_request(CMD_DISABLE,    3'd7, '0,            32'd0);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == RANDOM_REQUESTS / 2) begin
                wait_for_drain();
            end
            random_request();
        end

        i_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.failures == 0) begin
            $display("[multi_channel_deadline_timer_unit] OK");
        end else begin
            $display("[multi_channel_deadline_timer_unit] ERROR");
        end
        $finish;
    end

    // Result side: stalls follow a pattern that changes mode every so often, and
    // once holds off long enough for the block to back up and refuse requests.
    initial begin
        int unsigned seg_left;
        int unsigned hold_left;
        int unsigned cycle_cnt;
        bit          hold_done;
        logic        stall_next;
        t_rx_mode    mode;
        seg_left  = 0;
        hold_left = 0;
        cycle_cnt = 0;
        hold_done = 1'b0;
        mode      = RX_FREE;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (o_valid === 1'b1 && !i_stall) begin
                sb.check_result(o_fired_mask, o_nearest_deadline, o_channel_running);
            end
            if (!hold_done && sb.checked == HOLD_OFF_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (seg_left == 0) begin
                mode     = t_rx_mode'($urandom_range(0, 3));
                seg_left = $urandom_range(20, 200);
            end
            seg_left--;
            if (hold_left != 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else begin
                case (mode)
                    RX_LIGHT:    stall_next = ($urandom_range(0, 3) == 0);
                    RX_HEAVY:    stall_next = ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: stall_next = ((cycle_cnt % 5) < 2);
                    default:     stall_next = 1'b0;
                endcase
            end
            i_stall <= stall_next;
        end
    end

    initial begin
        #20_000_000;
        $display("[multi_channel_deadline_timer_unit] ERROR");
        $finish;
    end

endmodule

[filelist.f]
design/mcdt_pkg.sv
design/mcdt_rem.sv
design/multi_channel_deadline_timer_unit.sv
dv/multi_channel_deadline_timer_unit_tb.sv
